// ----- rtl/core/tpcg_pkg.sv -----
package tpcg_pkg;

  localparam int unsigned KHZ_W       = 22;
  localparam int unsigned STEP_W      = 20;
  localparam int unsigned TEMP_W      = 8;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned HOLD_W      = 12;
  localparam int unsigned FAIL_HOLD_W = 15;
  localparam int unsigned REP_W       = 2;
  localparam int unsigned CLASS_W     = 3;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [CNT_W-1:0] SAT8              = 8'd255;
  localparam logic [CNT_W-1:0] SINK_UNDO_WINDOW  = 8'd8;
  localparam logic [REP_W-1:0] FAIL_REPEAT_MAX   = 2'd3;
  localparam logic [CNT_W-1:0] CLIMB_TO_MAX_RUN  = 8'd2;
  localparam logic [CNT_W-1:0] FUTILE_SLIP_TICKS = 8'd4;

  // Frame-load classes; codes above LOAD_FF_SLIP act as an ordinary slip
  localparam logic [CLASS_W-1:0] LOAD_SLACK    = 3'd0;
  localparam logic [CLASS_W-1:0] LOAD_BUSY     = 3'd1;
  localparam logic [CLASS_W-1:0] LOAD_SLIP     = 3'd2;
  localparam logic [CLASS_W-1:0] LOAD_BIG_SLIP = 3'd3;
  localparam logic [CLASS_W-1:0] LOAD_FF_SLIP  = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_KHZ,
    CFG_MAX_KHZ,
    CFG_STEP_KHZ,
    CFG_TARGET_TEMP,
    CFG_HOT_TEMP,
    CFG_SLACK_DWELL,
    CFG_FAIL_HOLD,
    CFG_FUTILE_HOLD
  } tpcg_cfg_idx_t;

  localparam logic [KHZ_W-1:0]  RST_MIN_KHZ     = 22'd600000;
  localparam logic [KHZ_W-1:0]  RST_MAX_KHZ     = 22'd1800000;
  localparam logic [STEP_W-1:0] RST_STEP_KHZ    = 20'd216000;
  localparam logic [TEMP_W-1:0] RST_TARGET_TEMP = 8'd60;
  localparam logic [TEMP_W-1:0] RST_HOT_TEMP    = 8'd72;
  localparam logic [CNT_W-1:0]  RST_SLACK_DWELL = 8'd4;
  localparam logic [HOLD_W-1:0] RST_FAIL_HOLD   = 12'd120;
  localparam logic [HOLD_W-1:0] RST_FUTILE_HOLD = 12'd120;

  typedef struct packed {
    logic [KHZ_W-1:0]  min_khz;
    logic [KHZ_W-1:0]  max_khz;
    logic [STEP_W-1:0] step_khz;
    logic [TEMP_W-1:0] target_temp_c;
    logic [TEMP_W-1:0] hot_temp_c;
    logic [CNT_W-1:0]  slack_dwell_ticks;
    logic [HOLD_W-1:0] fail_hold_ticks;
    logic [HOLD_W-1:0] futile_hold_ticks;
  } tpcg_cfg_t;

  typedef struct packed {
    logic               mode;
    logic               temp_valid;
    logic [TEMP_W-1:0]  temp_c;
    logic [CLASS_W-1:0] load_class;
  } tpcg_item_t;

  typedef struct packed {
    logic [KHZ_W-1:0]       ceiling;
    logic [CNT_W-1:0]       slip_count;
    logic [CNT_W-1:0]       slack_count;
    logic [KHZ_W-1:0]       failed_ceiling;
    logic [FAIL_HOLD_W-1:0] fail_hold_left;
    logic [REP_W-1:0]       fail_repeats;
    logic [KHZ_W-1:0]       presink_ceiling;
    logic [CNT_W-1:0]       ticks_since_sink;
    logic [KHZ_W-1:0]       episode_origin;
    logic [CNT_W-1:0]       slips_at_max;
    logic [HOLD_W-1:0]      futile_hold_left;
  } tpcg_state_t;

  function automatic tpcg_state_t tpcg_reseed(input logic [KHZ_W-1:0] max_khz);
    tpcg_state_t s;
    s                  = '0;
    s.ceiling          = max_khz;
    s.ticks_since_sink = SAT8;
    return s;
  endfunction

endpackage

// ----- rtl/core/tpcg_if.sv -----
interface tpcg_item_if;
  import tpcg_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic               temp_valid;
  logic [TEMP_W-1:0]  temp_c;
  logic [CLASS_W-1:0] load_class;
  modport source (output valid, mode, temp_valid, temp_c, load_class, input ready);
  modport sink   (input valid, mode, temp_valid, temp_c, load_class, output ready);
endinterface

interface tpcg_result_if;
  import tpcg_pkg::*;
  logic             valid;
  logic             ready;
  logic [KHZ_W-1:0] ceiling_khz;
  modport source (output valid, ceiling_khz, input ready);
  modport sink   (input valid, ceiling_khz, output ready);
endinterface

interface tpcg_cfg_if;
  import tpcg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [KHZ_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/tpcg_cfg_regs.sv -----
module tpcg_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  tpcg_cfg_if.sink            cfg,
  output tpcg_pkg::tpcg_cfg_t regs
);
  import tpcg_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_khz           <= RST_MIN_KHZ;
      regs.max_khz           <= RST_MAX_KHZ;
      regs.step_khz          <= RST_STEP_KHZ;
      regs.target_temp_c     <= RST_TARGET_TEMP;
      regs.hot_temp_c        <= RST_HOT_TEMP;
      regs.slack_dwell_ticks <= RST_SLACK_DWELL;
      regs.fail_hold_ticks   <= RST_FAIL_HOLD;
      regs.futile_hold_ticks <= RST_FUTILE_HOLD;
    end else if (cfg.valid) begin
      case (tpcg_cfg_idx_t'(cfg.index))
        CFG_MIN_KHZ:     regs.min_khz           <= cfg.data;
        CFG_MAX_KHZ:     regs.max_khz           <= cfg.data;
        CFG_STEP_KHZ:    regs.step_khz          <= cfg.data[STEP_W-1:0];
        CFG_TARGET_TEMP: regs.target_temp_c     <= cfg.data[TEMP_W-1:0];
        CFG_HOT_TEMP:    regs.hot_temp_c        <= cfg.data[TEMP_W-1:0];
        CFG_SLACK_DWELL: regs.slack_dwell_ticks <= cfg.data[CNT_W-1:0];
        CFG_FAIL_HOLD:   regs.fail_hold_ticks   <= cfg.data[HOLD_W-1:0];
        CFG_FUTILE_HOLD: regs.futile_hold_ticks <= cfg.data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/tpcg_update.sv -----
module tpcg_update (
  input  tpcg_pkg::tpcg_item_t  item,
  input  tpcg_pkg::tpcg_state_t st,
  input  tpcg_pkg::tpcg_cfg_t   cfg,
  output tpcg_pkg::tpcg_state_t nx
);
  import tpcg_pkg::*;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    return (v < SAT8) ? v + 1'b1 : SAT8;
  endfunction

  logic [KHZ_W:0]         diff;
  logic [KHZ_W-1:0]       down;
  logic [KHZ_W:0]         up_sum;
  logic [KHZ_W-1:0]       up;
  logic [KHZ_W-1:0]       presink_cap;
  logic                   below_max;
  logic                   hot;
  logic                   cool;
  logic                   ff;
  logic [FAIL_HOLD_W-1:0] fhl_dec;
  logic [HOLD_W-1:0]      fut_dec;
  logic [CNT_W-1:0]       tss_inc;
  logic [CNT_W-1:0]       slip_inc;
  logic [CNT_W-1:0]       slack_inc;
  logic [CNT_W-1:0]       sam;
  logic [KHZ_W-1:0]       origin;
  logic [REP_W-1:0]       reps;
  logic                   sink_ok;

  // Shared one-step-down with floor at the minimum
  assign diff = {1'b0, st.ceiling} - {{(KHZ_W - STEP_W + 1){1'b0}}, cfg.step_khz};
  assign down = (diff[KHZ_W] || (diff[KHZ_W-1:0] < cfg.min_khz)) ? cfg.min_khz
                                                                 : diff[KHZ_W-1:0];
  // One-step climb capped at the maximum
  assign up_sum = {1'b0, st.ceiling} + {{(KHZ_W - STEP_W + 1){1'b0}}, cfg.step_khz};
  assign up     = (up_sum > {1'b0, cfg.max_khz}) ? cfg.max_khz : up_sum[KHZ_W-1:0];
  assign presink_cap = (st.presink_ceiling > cfg.max_khz) ? cfg.max_khz
                                                          : st.presink_ceiling;

  assign below_max = st.ceiling < cfg.max_khz;
  assign hot       = item.temp_valid && (item.temp_c >= cfg.hot_temp_c);
  assign cool      = !item.temp_valid || (item.temp_c <= cfg.target_temp_c);
  assign ff        = item.load_class == LOAD_FF_SLIP;
  assign fhl_dec   = (st.fail_hold_left != '0) ? st.fail_hold_left - 1'b1 : '0;
  assign fut_dec   = (st.futile_hold_left != '0) ? st.futile_hold_left - 1'b1 : '0;
  assign tss_inc   = inc_sat(st.ticks_since_sink);
  assign slip_inc  = inc_sat(st.slip_count);
  assign slack_inc = inc_sat(st.slack_count);

  assign sink_ok = (slack_inc >= cfg.slack_dwell_ticks) && cool &&
                   ((fhl_dec == '0) || (down > st.failed_ceiling)) &&
                   (st.ceiling > cfg.min_khz);

  always_comb begin
    nx     = st;
    sam    = st.slips_at_max;
    origin = st.episode_origin;
    reps   = '0;
    if (item.mode) begin
      nx = tpcg_reseed(cfg.max_khz);
    end else if (hot) begin
      nx.ceiling     = down;
      nx.slip_count  = '0;
      nx.slack_count = '0;
    end else begin
      nx.fail_hold_left   = fhl_dec;
      nx.futile_hold_left = fut_dec;
      nx.ticks_since_sink = tss_inc;
      case (item.load_class)
        LOAD_BUSY: begin
          nx.slip_count = '0;
        end
        LOAD_SLACK: begin
          nx.slack_count    = slack_inc;
          nx.slip_count     = '0;
          nx.slips_at_max   = '0;
          nx.episode_origin = '0;
          if (sink_ok) begin
            nx.presink_ceiling  = st.ceiling;
            nx.ticks_since_sink = '0;
            nx.ceiling          = down;
            nx.slack_count      = '0;
          end
        end
        default: begin
          if ((fut_dec != '0) && !ff) begin
            nx.slack_count = '0;
          end else if (!ff && !below_max && (inc_sat(st.slips_at_max) >= FUTILE_SLIP_TICKS)
                       && (st.episode_origin != '0)
                       && (st.episode_origin < cfg.max_khz)) begin
            // Futile climb: fall back to where the episode began and hold
            nx.ceiling          = st.episode_origin;
            nx.futile_hold_left = cfg.futile_hold_ticks;
            nx.slips_at_max     = '0;
            nx.slip_count       = '0;
            nx.slack_count      = '0;
          end else begin
            if (!ff) begin
              if ((st.slip_count == '0) && below_max) begin
                origin = st.ceiling;
              end
              sam = below_max ? '0 : inc_sat(st.slips_at_max);
            end
            nx.episode_origin = origin;
            nx.slips_at_max   = sam;
            nx.slip_count     = slip_inc;
            nx.slack_count    = '0;
            if (below_max) begin
              if ((st.failed_ceiling != '0) && (st.ceiling <= st.failed_ceiling)) begin
                reps = (st.fail_repeats < FAIL_REPEAT_MAX) ? st.fail_repeats + 1'b1
                                                           : st.fail_repeats;
              end
              nx.fail_repeats = reps;
              if (st.ceiling > st.failed_ceiling) begin
                nx.failed_ceiling = st.ceiling;
              end
              nx.fail_hold_left = {{(FAIL_HOLD_W - HOLD_W){1'b0}}, cfg.fail_hold_ticks}
                                  << reps;
              if ((item.load_class == LOAD_BIG_SLIP) || ff) begin
                nx.ceiling = cfg.max_khz;
              end else if ((tss_inc < SINK_UNDO_WINDOW)
                           && (st.presink_ceiling > st.ceiling)) begin
                nx.ceiling = presink_cap;
              end else if (slip_inc >= CLIMB_TO_MAX_RUN) begin
                nx.ceiling = cfg.max_khz;
              end else begin
                nx.ceiling = up;
              end
            end
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/thermal_perf_clock_ceiling_governor.sv -----
// Channel  Role    Payload                                  Accepted when
// item     sink    mode, temp_valid, temp_c, load_class     item.valid && item.ready
// result   source  ceiling_khz                              result.valid && result.ready
// cfg      sink    index, data                              cfg.valid && cfg.ready
//
// One beat in, one beat out. A tick is captured in the input register, the update
// logic runs, and the new state and ceiling land together; sustained rate is one beat
// per cycle while result.ready holds, and the result is shown from the result register.
// Synchronous reset loads the register defaults and the governor state.
// A stalled result only blocks the input register once both hold a beat.
module thermal_perf_clock_ceiling_governor (
  input  logic          clk,
  input  logic          rst,
  tpcg_cfg_if.sink      cfg,
  tpcg_item_if.sink     item,
  tpcg_result_if.source result
);
  import tpcg_pkg::*;

  tpcg_cfg_t        cur_cfg;
  tpcg_item_t       held_item;
  logic             held_valid;
  tpcg_state_t      st;
  tpcg_state_t      st_next;
  logic             res_valid;
  logic [KHZ_W-1:0] res_ceiling;
  logic             advance;

  tpcg_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cur_cfg)
  );

  tpcg_update u_update (
    .item (held_item),
    .st   (st),
    .cfg  (cur_cfg),
    .nx   (st_next)
  );

  // Advance the held tick when the result register is free or being drained
  assign advance    = held_valid && (!res_valid || result.ready);
  assign item.ready = !held_valid || advance;

  assign result.valid       = res_valid;
  assign result.ceiling_khz = res_ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      res_valid  <= 1'b0;
      st         <= tpcg_reseed(RST_MAX_KHZ);
    end else begin
      if (item.ready) begin
        held_valid <= item.valid;
      end
      if (advance) begin
        st        <= st_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload: capture the beat and the result, no reset needed
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held_item.mode       <= item.mode;
      held_item.temp_valid <= item.temp_valid;
      held_item.temp_c     <= item.temp_c;
      held_item.load_class <= item.load_class;
    end
    if (advance) begin
      res_ceiling <= st_next.ceiling;
    end
  end

`ifndef SYNTHESIS
  // The shown result always matches the stored ceiling it was taken from
  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    (advance) |=> (res_ceiling == st.ceiling))
    else $error("result ceiling differs from state ceiling");

  // A scene change reseeds the ceiling to the maximum then in force
  a_scene_reseeds: assert property (@(posedge clk) disable iff (rst)
    (advance && held_item.mode) |=> (st.ceiling == $past(cur_cfg.max_khz)
                                     && st.slip_count == '0 && st.fail_hold_left == '0))
    else $error("scene change did not reseed state");

  // Nothing is shown straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!res_valid && !held_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- tb/thermal_perf_clock_ceiling_governor_test.sv -----
`timescale 1ns / 100ps

module thermal_perf_clock_ceiling_governor_test;
  import tpcg_pkg::*;

  // Class codes above the named ones are spare; the governor treats them as a plain slip
  localparam logic [CLASS_W-1:0] LOAD_CLASS_TOP = 3'd7;

  // Cycles with no beat on any channel before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;

  // Items per randomised setting, and number of settings
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned PHASES      = 7;

  typedef enum {RUN_SLACK, RUN_SLIP, RUN_BUSY, RUN_HOT, RUN_NOISE} run_kind_t;

  // Governor shadow: register copy, state copy and the queue of ceilings owed by the block
  class ceiling_scoreboard;
    tpcg_cfg_t        regs;
    tpcg_state_t      st;
    logic [KHZ_W-1:0] ceiling_due[$];
    int unsigned      mismatches;

    function new();
      regs.min_khz           = RST_MIN_KHZ;
      regs.max_khz           = RST_MAX_KHZ;
      regs.step_khz          = RST_STEP_KHZ;
      regs.target_temp_c     = RST_TARGET_TEMP;
      regs.hot_temp_c        = RST_HOT_TEMP;
      regs.slack_dwell_ticks = RST_SLACK_DWELL;
      regs.fail_hold_ticks   = RST_FAIL_HOLD;
      regs.futile_hold_ticks = RST_FUTILE_HOLD;
      mismatches             = 0;
      reseed_state();
    endfunction

    function void reseed_state();
      st.ceiling          = regs.max_khz;
      st.slip_count       = '0;
      st.slack_count      = '0;
      st.failed_ceiling   = '0;
      st.fail_hold_left   = '0;
      st.fail_repeats     = '0;
      st.presink_ceiling  = '0;
      st.ticks_since_sink = SAT8;
      st.episode_origin   = '0;
      st.slips_at_max     = '0;
      st.futile_hold_left = '0;
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == SAT8) ? v : v + 1'b1;
    endfunction

    // One step down, floored at min_khz (also catches a step below zero)
    function logic [KHZ_W-1:0] step_down_khz(logic [KHZ_W-1:0] c);
      longint n;
      n = longint'(c) - longint'(regs.step_khz);
      if (n < longint'(regs.min_khz)) n = longint'(regs.min_khz);
      return n[KHZ_W-1:0];
    endfunction

    function void apply_slip(logic [CLASS_W-1:0] cls);
      bit               ff;
      logic [KHZ_W:0]   climb_khz;
      ff = (cls == LOAD_FF_SLIP);
      if (st.futile_hold_left != 0 && !ff) begin
        st.slack_count = '0;
        return;
      end
      if (!ff) begin
        if (st.slip_count == 0 && st.ceiling < regs.max_khz) st.episode_origin = st.ceiling;
        if (st.ceiling >= regs.max_khz) begin
          st.slips_at_max = bump(st.slips_at_max);
          if (st.slips_at_max >= FUTILE_SLIP_TICKS && st.episode_origin != 0 &&
              st.episode_origin < regs.max_khz) begin
            st.ceiling          = st.episode_origin;
            st.futile_hold_left = regs.futile_hold_ticks;
            st.slips_at_max     = '0;
            st.slip_count       = '0;
            st.slack_count      = '0;
            return;
          end
        end else begin
          st.slips_at_max = '0;
        end
      end
      if (st.ceiling < regs.max_khz) begin
        if (st.failed_ceiling != 0 && st.ceiling <= st.failed_ceiling) begin
          if (st.fail_repeats < FAIL_REPEAT_MAX) st.fail_repeats = st.fail_repeats + 1'b1;
        end else begin
          st.fail_repeats = '0;
        end
        if (st.ceiling > st.failed_ceiling) st.failed_ceiling = st.ceiling;
        st.fail_hold_left = {3'b000, regs.fail_hold_ticks} << st.fail_repeats;
      end
      st.slip_count  = bump(st.slip_count);
      st.slack_count = '0;
      if (st.ceiling < regs.max_khz) begin
        if (cls == LOAD_BIG_SLIP || ff)
          climb_khz = {1'b0, regs.max_khz};
        else if (st.ticks_since_sink < SINK_UNDO_WINDOW && st.presink_ceiling > st.ceiling)
          climb_khz = {1'b0, st.presink_ceiling};
        else if (st.slip_count >= CLIMB_TO_MAX_RUN)
          climb_khz = {1'b0, regs.max_khz};
        else
          climb_khz = {1'b0, st.ceiling} + {3'b000, regs.step_khz};
        if (climb_khz > {1'b0, regs.max_khz}) climb_khz = {1'b0, regs.max_khz};
        st.ceiling = climb_khz[KHZ_W-1:0];
      end
    endfunction

    function void apply_slack(logic valid, logic [TEMP_W-1:0] temp);
      bit               cool;
      bit               clear_of_fail;
      logic [KHZ_W-1:0] lower;
      st.slack_count    = bump(st.slack_count);
      st.slip_count     = '0;
      st.slips_at_max   = '0;
      st.episode_origin = '0;
      cool          = !valid || temp <= regs.target_temp_c;
      lower         = step_down_khz(st.ceiling);
      clear_of_fail = (st.fail_hold_left == 0) || (lower > st.failed_ceiling);
      if (st.slack_count >= regs.slack_dwell_ticks && cool && clear_of_fail &&
          st.ceiling > regs.min_khz) begin
        st.presink_ceiling  = st.ceiling;
        st.ticks_since_sink = '0;
        st.ceiling          = lower;
        st.slack_count      = '0;
      end
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [KHZ_W-1:0] word);
      case (idx)
        CFG_MIN_KHZ:     regs.min_khz           = word;
        CFG_MAX_KHZ:     regs.max_khz           = word;
        CFG_STEP_KHZ:    regs.step_khz          = word[STEP_W-1:0];
        CFG_TARGET_TEMP: regs.target_temp_c     = word[TEMP_W-1:0];
        CFG_HOT_TEMP:    regs.hot_temp_c        = word[TEMP_W-1:0];
        CFG_SLACK_DWELL: regs.slack_dwell_ticks = word[CNT_W-1:0];
        CFG_FAIL_HOLD:   regs.fail_hold_ticks   = word[HOLD_W-1:0];
        CFG_FUTILE_HOLD: regs.futile_hold_ticks = word[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(tpcg_item_t t);
      if (t.mode) begin
        reseed_state();
      end else if (t.temp_valid && t.temp_c >= regs.hot_temp_c) begin
        st.ceiling     = step_down_khz(st.ceiling);
        st.slip_count  = '0;
        st.slack_count = '0;
      end else begin
        if (st.fail_hold_left != 0) st.fail_hold_left = st.fail_hold_left - 1'b1;
        if (st.futile_hold_left != 0) st.futile_hold_left = st.futile_hold_left - 1'b1;
        st.ticks_since_sink = bump(st.ticks_since_sink);
        if (t.load_class == LOAD_BUSY)
          st.slip_count = '0;
        else if (t.load_class != LOAD_SLACK)
          apply_slip(t.load_class);
        else
          apply_slack(t.temp_valid, t.temp_c);
      end
      ceiling_due.push_back(st.ceiling);
    endfunction

    function int unsigned pending();
      return ceiling_due.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_ceiling(logic [KHZ_W-1:0] got);
      logic [KHZ_W-1:0] want;
      if (ceiling_due.size() == 0) begin
        report($sformatf("ceiling_khz %0d arrived with nothing expected", got));
        return;
      end
      want = ceiling_due.pop_front();
      if (got !== want) report($sformatf("ceiling_khz got %0d, expected %0d", got, want));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        take_ok = 1'b0;
  bit          calm = 1'b0;
  int unsigned quiet = 0;

  ceiling_scoreboard sb;

  tpcg_cfg_if    cfg_bus ();
  tpcg_item_if   item_bus ();
  tpcg_result_if result_bus ();

  thermal_perf_clock_ceiling_governor i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .item   (item_bus),
    .result (result_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random gap or stall decision, shared by both ends; none while calm is set
  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 9);
  endfunction

  // Result side: stall now and then by dropping ready
  assign result_bus.ready = take_ok;
  always @(posedge clk) take_ok <= !idle_now();

  // Watch every channel on the edge: shadow register writes, predict each accepted tick,
  // then compare each accepted result against the oldest owed ceiling.
  always @(posedge clk) begin : watch_beats
    tpcg_item_t t;
    if (cfg_bus.valid && cfg_bus.ready) sb.load_reg(cfg_bus.index, cfg_bus.data);
    if (item_bus.valid && item_bus.ready) begin
      t = {item_bus.mode, item_bus.temp_valid, item_bus.temp_c, item_bus.load_class};
      sb.note_tick(t);
    end
    if (result_bus.valid && result_bus.ready) sb.check_ceiling(result_bus.ceiling_khz);
  end

  // Hang guard: count cycles in which no beat moves on any channel
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one tick, with random gaps ahead of it; return on the edge that takes it.
  // Ready is judged at the falling edge, where nothing is moving.
  task automatic send_tick(input tpcg_item_t t);
    bit took;
    while (idle_now()) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.mode       <= t.mode;
    item_bus.temp_valid <= t.temp_valid;
    item_bus.temp_c     <= t.temp_c;
    item_bus.load_class <= t.load_class;
    do begin
      @(negedge clk);
      took = (item_bus.ready === 1'b1);
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_fields(input bit m, input bit tv, input logic [TEMP_W-1:0] temp,
                             input logic [CLASS_W-1:0] cls);
    send_tick({m, tv, temp, cls});
  endtask

  // Leaves cfg valid high; the caller drops it after the last write
  task automatic write_reg_beat(input tpcg_cfg_idx_t idx, input logic [KHZ_W-1:0] word);
    bit took;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= word;
    do begin
      @(negedge clk);
      took = (cfg_bus.ready === 1'b1);
      @(posedge clk);
    end while (!took);
  endtask

  // Drop the tick stream and hold until every owed ceiling has come back
  task automatic hold_until_drained();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // A tick at or below the target temperature most of the time, with the odd stray reading
  function automatic tpcg_item_t cool_tick(input logic [CLASS_W-1:0] cls);
    tpcg_item_t t;
    t.mode       = 1'b0;
    t.load_class = cls;
    t.temp_valid = ($urandom_range(15) != 0);
    if ($urandom_range(4) == 0)
      t.temp_c = TEMP_W'($urandom);
    else
      t.temp_c = TEMP_W'($urandom_range(sb.regs.target_temp_c));
    return t;
  endfunction

  initial begin
    tpcg_cfg_t        setting;
    tpcg_item_t       t;
    run_kind_t        kind;
    logic [KHZ_W-1:0] junk;
    int unsigned      lo, hi, span, pick, run, sent;
    bit               paused;

    rst                 = 1'b1;
    item_bus.valid      = 1'b0;
    item_bus.mode       = 1'b0;
    item_bus.temp_valid = 1'b0;
    item_bus.temp_c     = '0;
    item_bus.load_class = LOAD_SLACK;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = CFG_MIN_KHZ;
    cfg_bus.data        = '0;
    sb = new();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed walk at the reset settings (600000..1800000 in 216000 steps, 60/72 C).
    // Four cool slack beats meet the dwell: sink one step, temperature at zero
    repeat (4) send_fields(1'b0, 1'b1, 8'd0, LOAD_SLACK);
    // Slip right after the sink, at exactly the target: undo to the pre-sink ceiling
    send_fields(1'b0, 1'b1, 8'd60, LOAD_SLIP);
    // Slips pinned at max: the fourth is futile and drops back to the episode origin
    repeat (4) send_fields(1'b0, 1'b1, 8'd71, LOAD_SLIP);
    // Ordinary slip is held off; fast-forward slip ignores the hold and jumps to max
    send_fields(1'b0, 1'b1, 8'd50, LOAD_SLIP);
    send_fields(1'b0, 1'b1, 8'd50, LOAD_FF_SLIP);
    // Thermal backstop right at the hot threshold, and at full scale
    send_fields(1'b0, 1'b1, 8'd72, LOAD_BUSY);
    send_fields(1'b0, 1'b1, 8'd255, LOAD_SLACK);
    // Unreadable sensor showing full scale: no backstop, counts as cool slack
    send_fields(1'b0, 1'b0, 8'd255, LOAD_SLACK);
    send_fields(1'b0, 1'b1, 8'd61, LOAD_BUSY);
    send_fields(1'b0, 1'b1, 8'd40, LOAD_BIG_SLIP);
    // Scene change with junk in every other field
    send_fields(1'b1, 1'b1, 8'd255, LOAD_CLASS_TOP);
    // Spare class codes behave as an ordinary slip
    for (int c = LOAD_FF_SLIP + 1; c <= LOAD_CLASS_TOP; c++)
      send_fields(1'b0, 1'b1, 8'd10, CLASS_W'(c));
    // Backstop all the way down onto the floor, then climb by a step and then to max
    repeat (6) send_fields(1'b0, 1'b1, 8'd200, LOAD_BUSY);
    repeat (2) send_fields(1'b0, 1'b1, 8'd30, LOAD_SLIP);
    hold_until_drained();
    repeat (4) @(posedge clk);

    for (int phase = 1; phase <= PHASES; phase++) begin
      // A plausible governor setting first; some phases then pin the extremes
      lo   = $urandom_range(2000000);
      hi   = $urandom_range(4000000, lo);
      span = (hi - lo) / 4 + 1;
      if (span > 1000000) span = 1000000;
      setting.min_khz           = KHZ_W'(lo);
      setting.max_khz           = KHZ_W'(hi);
      setting.step_khz          = STEP_W'($urandom_range(span, 1));
      setting.target_temp_c     = TEMP_W'($urandom_range(90, 20));
      setting.hot_temp_c        = TEMP_W'($urandom_range(110, setting.target_temp_c));
      setting.slack_dwell_ticks = CNT_W'($urandom_range(6, 1));
      setting.fail_hold_ticks   = HOLD_W'(($urandom_range(9) == 0) ? $urandom_range(4095)
                                                                     : $urandom_range(30));
      setting.futile_hold_ticks = HOLD_W'(($urandom_range(9) == 0) ? $urandom_range(4095)
                                                                     : $urandom_range(30));
      case (phase)
        1: begin
          setting = '{min_khz: 22'd0, max_khz: 22'd4000000, step_khz: 20'd1,
                      target_temp_c: 8'd255, hot_temp_c: 8'd255, slack_dwell_ticks: 8'd1,
                      fail_hold_ticks: 12'd0, futile_hold_ticks: 12'd0};
        end
        2: begin
          setting = '{min_khz: 22'd0, max_khz: 22'd4000000, step_khz: 20'd1000000,
                      target_temp_c: 8'd0, hot_temp_c: 8'd0, slack_dwell_ticks: 8'd255,
                      fail_hold_ticks: 12'd4095, futile_hold_ticks: 12'd4095};
        end
        3: begin
          // Floor above ceiling, both at their outer limits
          setting.min_khz = 22'd4000000;
          setting.max_khz = 22'd0;
        end
        5: begin
          // Inverted bounds with ordinary values
          setting.min_khz = KHZ_W'(hi);
          setting.max_khz = KHZ_W'(lo);
        end
        default: ;
      endcase
      // Phase 4 runs with both ends flat out
      calm = (phase == 4);

      // Narrow registers get random junk above their width
      junk = KHZ_W'($urandom);
      write_reg_beat(CFG_MIN_KHZ, setting.min_khz);
      write_reg_beat(CFG_MAX_KHZ, setting.max_khz);
      write_reg_beat(CFG_STEP_KHZ, {junk[KHZ_W-1:STEP_W], setting.step_khz});
      write_reg_beat(CFG_TARGET_TEMP, {junk[KHZ_W-1:TEMP_W], setting.target_temp_c});
      write_reg_beat(CFG_HOT_TEMP, {junk[KHZ_W-1:TEMP_W], setting.hot_temp_c});
      write_reg_beat(CFG_SLACK_DWELL, {junk[KHZ_W-1:CNT_W], setting.slack_dwell_ticks});
      write_reg_beat(CFG_FAIL_HOLD, {junk[KHZ_W-1:HOLD_W], setting.fail_hold_ticks});
      write_reg_beat(CFG_FUTILE_HOLD, {junk[KHZ_W-1:HOLD_W], setting.futile_hold_ticks});
      cfg_bus.valid <= 1'b0;

      // Runs of like ticks, so dwells fill and slip episodes reach the futile detector
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          hold_until_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
          kind = RUN_SLACK;
          run  = $urandom_range(10, 1);
        end else if (pick < 70) begin
          kind = RUN_SLIP;
          run  = $urandom_range(7, 1);
        end else if (pick < 85) begin
          kind = RUN_BUSY;
          run  = $urandom_range(3, 1);
        end else if (pick < 95) begin
          kind = RUN_HOT;
          run  = $urandom_range(3, 1);
        end else begin
          kind = RUN_NOISE;
          run  = 1;
        end
        for (int k = 0; k < run; k++) begin
          case (kind)
            RUN_SLACK: t = cool_tick(LOAD_SLACK);
            RUN_BUSY:  t = cool_tick(LOAD_BUSY);
            RUN_SLIP: begin
              pick = $urandom_range(19);
              if (pick == 0)
                t = cool_tick(LOAD_BIG_SLIP);
              else if (pick == 1)
                t = cool_tick(LOAD_FF_SLIP);
              else if (pick == 2)
                t = cool_tick(CLASS_W'($urandom_range(LOAD_CLASS_TOP, LOAD_FF_SLIP + 1)));
              else
                t = cool_tick(LOAD_SLIP);
            end
            RUN_HOT: begin
              t.mode       = 1'b0;
              t.temp_valid = 1'b1;
              t.temp_c     = TEMP_W'($urandom_range(255, sb.regs.hot_temp_c));
              t.load_class = CLASS_W'($urandom);
            end
            default: begin
              t.mode       = ($urandom_range(3) == 0);
              t.temp_valid = 1'($urandom);
              t.temp_c     = TEMP_W'($urandom);
              t.load_class = CLASS_W'($urandom);
            end
          endcase
          send_tick(t);
          sent++;
        end
      end
      hold_until_drained();
      repeat (4) @(posedge clk);
    end

    calm = 1'b0;
    hold_until_drained();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tpcg_pkg.sv
rtl/core/tpcg_if.sv
rtl/core/tpcg_cfg_regs.sv
rtl/core/tpcg_update.sv
rtl/core/thermal_perf_clock_ceiling_governor.sv
tb/thermal_perf_clock_ceiling_governor_test.sv
